[rtl/skl_pkg.sv]
// ----------------------------------------------------------------------------
// skl_pkg: shared types for the sorted key list
// Command and status enums, request and response structs plus the per-cell control bundle.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int unsigned KeyW   = 31;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    cmd_e command;
    key_t key;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] count;
  } rsp_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic ins;  // insert shifts toward the tail
    logic rem;  // remove shifts toward the head
    key_t key;
  } skl_ctrl_t;

endpackage

[rtl/skl_cell.sv]
// ----------------------------------------------------------------------------
// skl_cell: one slot of the sorted key list
// Holds a key, compares it with the broadcast key, trades with neighbors.
// ----------------------------------------------------------------------------
module skl_cell
  import skl_pkg::*;
(
  input  logic      clk_i,
  input  skl_ctrl_t ctrl_i,
  input  logic      occ_i,       // slot holds a live entry
  input  logic      left_le_i,   // left neighbor stays put on insert
  input  key_t      left_key_i,
  input  key_t      right_key_i,
  output key_t      key_o,
  output logic      le_o,        // live and key <= broadcast key
  output logic      eq_o         // live and key == broadcast key
);

  key_t key_q, key_d;
  logic ge;

  assign le_o = occ_i && (key_q <= ctrl_i.key);
  assign eq_o = occ_i && (key_q == ctrl_i.key);
  assign ge   = occ_i && (key_q >= ctrl_i.key);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !le_o) begin
      // first slot past the equal run takes the new key, later ones shift
      key_d = left_le_i ? ctrl_i.key : left_key_i;
    end else if (ctrl_i.rem && ge) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

[rtl/sorted_key_list_unit.sv]
// ----------------------------------------------------------------------------
// sorted_key_list_unit: bounded ascending key list
// Row of compare-and-shift cells with a shared entry counter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and pulse start. The item is taken on the
//   rising edge where start is high and busy is low. busy never rises: every
//   cell compares its key with the incoming key in parallel, so an insert or
//   remove shifts the whole row in the same edge that takes the item.
//   Throughput is one item per cycle, back to back.
//   Result channel: done_o is high for exactly one cycle, the cycle after
//   the item was taken, with rsp_o holding status and the count after it.
//   The receiver cannot stall, so it must sample on every done_o.
//   Insert places the key after any equal keys; a full list drops it and
//   reports ST_FULL. Remove deletes the first equal entry from the head;
//   an empty list reports ST_EMPTY, an absent key ST_MISSING.
//   Reset clears the entry count and done_o; the cell keys are left as they
//   are, since only slots below the count are ever compared.
//   A count wider than seven bits (CAPACITY above 127) is reported modulo 128.
// ----------------------------------------------------------------------------
module sorted_key_list_unit
  import skl_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  rsp_t            rsp_q, rsp_d;

  logic            accept, full, empty, found;
  skl_ctrl_t       ctrl;
  key_t            cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_le, cell_eq, cell_occ;

  // updates finish in the accepting edge
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (cnt_q == CntW'(CAPACITY));
  assign empty = (cnt_q == '0);
  assign found = |cell_eq;   // sorted row: any hit means a first hit exists

  always_comb begin
    ctrl.key = req_i.key;
    ctrl.ins = accept && (req_i.command == CMD_INSERT) && !full;
    ctrl.rem = accept && (req_i.command == CMD_REMOVE) && found;
  end

  // cell row: slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CntW'(i) < cnt_q);

    if (i == 0) begin : g_head
      skl_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (cell_occ[i]),
        .left_le_i  (1'b1),
        .left_key_i (req_i.key),
        .right_key_i(cell_key[(i+1) % CAPACITY]),
        .key_o      (cell_key[i]),
        .le_o       (cell_le[i]),
        .eq_o       (cell_eq[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      // tail has no right neighbor; its key is dead after a remove anyway
      skl_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (cell_occ[i]),
        .left_le_i  (cell_le[i-1]),
        .left_key_i (cell_key[i-1]),
        .right_key_i(cell_key[i]),
        .key_o      (cell_key[i]),
        .le_o       (cell_le[i]),
        .eq_o       (cell_eq[i])
      );
    end else begin : g_mid
      skl_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (cell_occ[i]),
        .left_le_i  (cell_le[i-1]),
        .left_key_i (cell_key[i-1]),
        .right_key_i(cell_key[i+1]),
        .key_o      (cell_key[i]),
        .le_o       (cell_le[i]),
        .eq_o       (cell_eq[i])
      );
    end
  end

  // count and status
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - 1'b1;
    end

    rsp_d.count = CountW'(cnt_d);
    if (req_i.command == CMD_INSERT) begin
      rsp_d.status = full ? ST_FULL : ST_OK;
    end else if (empty) begin
      rsp_d.status = ST_EMPTY;
    end else begin
      rsp_d.status = found ? ST_OK : ST_MISSING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted item gave no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without an item");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (cnt_q == CntW'(CAPACITY)))
    else $error("full status with free slots");

  a_ok_moves_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (ctrl.ins || ctrl.rem)) |=> (cnt_q != $past(cnt_q)))
    else $error("successful item left count unchanged");

endmodule
